// File: rtl/nqs_pkg.sv
package nqs_pkg;

  localparam int unsigned DefaultMaxSize = 16;

  localparam int unsigned BoardSizeW = 5;
  localparam int unsigned IndexW     = 4;

endpackage

// File: rtl/nqs_row_mem.sv
module nqs_row_mem #(
  parameter int unsigned MaxSize = nqs_pkg::DefaultMaxSize,
  parameter int unsigned RowW    = $clog2(MaxSize)
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [RowW-1:0] waddr_i,
  input  logic [RowW-1:0] wdata_i,
  input  logic [RowW-1:0] raddr_i,
  output logic [RowW-1:0] rdata_o
);
  import nqs_pkg::*;

  logic [RowW-1:0] mem_q [MaxSize];
  logic [RowW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/nqs_occupancy.sv
module nqs_occupancy #(
  parameter int unsigned MaxSize = nqs_pkg::DefaultMaxSize,
  parameter int unsigned RowW    = $clog2(MaxSize)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            clr_i,
  input  logic            tgl_i,
  input  logic [RowW-1:0] row_i,
  input  logic [RowW-1:0] col_i,
  output logic            free_o
);
  import nqs_pkg::*;

  localparam int unsigned DiagN = 2 * MaxSize - 1;
  localparam int unsigned DiagW = $clog2(DiagN);

  logic [MaxSize-1:0] row_taken_q;
  logic [DiagN-1:0]   rise_taken_q;
  logic [DiagN-1:0]   fall_taken_q;
  logic [DiagW-1:0]   rise_idx;
  logic [DiagW-1:0]   fall_idx;

  assign rise_idx = DiagW'(row_i) + DiagW'(col_i);
  assign fall_idx = DiagW'(row_i) + DiagW'(MaxSize - 1) - DiagW'(col_i);

  assign free_o = !row_taken_q[row_i] && !rise_taken_q[rise_idx] && !fall_taken_q[fall_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_taken_q  <= '0;
      rise_taken_q <= '0;
      fall_taken_q <= '0;
    end else if (clr_i) begin
      row_taken_q  <= '0;
      rise_taken_q <= '0;
      fall_taken_q <= '0;
    end else if (tgl_i) begin
      row_taken_q[row_i]     <= ~row_taken_q[row_i];
      rise_taken_q[rise_idx] <= ~rise_taken_q[rise_idx];
      fall_taken_q[fall_idx] <= ~fall_taken_q[fall_idx];
    end
  end

endmodule

// File: rtl/n_queens_first_solution_search.sv
// N-queens first-solution search.
// Input channel (in_valid_i/in_ready_o, board_size_i): one transaction starts a
// depth-first search for the first placement on an N x N board. Sizes above
// MAX_SIZE saturate to MAX_SIZE. in_ready_o is high only while no search is
// running; one board is handled at a time.
// Output channel (out_valid_o/out_ready_i): on success N transactions, one per
// column in column order, with found_o=1 and last_o on the final one. With no
// placement (sizes 0, 2, 3) a single transaction with found_o=0, last_o=1.
// The search tests candidate rows in StScan. A backtrack step passes through
// StScan and StBack, and each result through StFetch and StSend, since the row
// memory has one read port and a registered read.
// Results leave through one output register, so the next board is accepted
// while the final result still waits. A stalled receiver holds the current
// result and pauses the emission; the search itself never waits on it.
// Reset clears the sequencer, occupancy masks and output valid; the row memory
// is not cleared, since every entry is written before it is read.
module n_queens_first_solution_search #(
  parameter int unsigned MAX_SIZE = nqs_pkg::DefaultMaxSize
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [nqs_pkg::BoardSizeW-1:0]   board_size_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             found_o,
  output logic [nqs_pkg::IndexW-1:0]       column_index_o,
  output logic [nqs_pkg::IndexW-1:0]       row_index_o,
  output logic                             last_o
);
  import nqs_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_SIZE + 1);
  localparam int unsigned RowW = $clog2(MAX_SIZE);

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StBack,
    StFetch,
    StSend,
    StFail
  } state_e;

  state_e              state_q, state_d;
  logic [CntW-1:0]     n_q, n_d;
  logic [CntW-1:0]     col_q, col_d;
  logic [CntW-1:0]     row_q, row_d;
  logic                out_valid_q, out_valid_d;
  logic                found_q, found_d;
  logic [IndexW-1:0]   colidx_q, colidx_d;
  logic [IndexW-1:0]   rowidx_q, rowidx_d;
  logic                last_q, last_d;

  logic [CntW-1:0]     size_sat;
  logic                out_free;
  logic                is_last;
  logic                mem_we;
  logic [RowW-1:0]     mem_raddr;
  logic [RowW-1:0]     mem_rdata;
  logic                occ_clr;
  logic                occ_tgl;
  logic [RowW-1:0]     occ_row;
  logic [RowW-1:0]     occ_col;
  logic                occ_free;

  assign size_sat = (int'(board_size_i) > int'(MAX_SIZE)) ? CntW'(MAX_SIZE)
                                                          : CntW'(board_size_i);
  assign out_free  = !out_valid_q || out_ready_i;
  assign is_last   = (CntW'(col_q + CntW'(1)) == n_q);
  assign mem_raddr = (state_q == StScan) ? RowW'(col_q - CntW'(1)) : RowW'(col_q);

  nqs_row_mem #(
    .MaxSize (MAX_SIZE),
    .RowW    (RowW)
  ) u_row_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (RowW'(col_q)),
    .wdata_i (RowW'(row_q)),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  nqs_occupancy #(
    .MaxSize (MAX_SIZE),
    .RowW    (RowW)
  ) u_occupancy (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (occ_clr),
    .tgl_i   (occ_tgl),
    .row_i   (occ_row),
    .col_i   (occ_col),
    .free_o  (occ_free)
  );

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    col_d       = col_q;
    row_d       = row_q;
    out_valid_d = out_valid_q && !out_ready_i;
    found_d     = found_q;
    colidx_d    = colidx_q;
    rowidx_d    = rowidx_q;
    last_d      = last_q;
    mem_we      = 1'b0;
    occ_clr     = 1'b0;
    occ_tgl     = 1'b0;
    occ_row     = RowW'(row_q);
    occ_col     = RowW'(col_q);

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          n_d     = size_sat;
          col_d   = '0;
          row_d   = '0;
          occ_clr = 1'b1;
          state_d = (size_sat == '0) ? StFail : StScan;
        end
      end
      StScan: begin
        if (col_q == n_q) begin
          col_d   = '0;
          state_d = StFetch;
        end else if (row_q == n_q) begin
          if (col_q == '0) begin
            state_d = StFail;
          end else begin
            col_d   = col_q - CntW'(1);
            state_d = StBack;
          end
        end else if (occ_free) begin
          occ_tgl = 1'b1;
          mem_we  = 1'b1;
          col_d   = col_q + CntW'(1);
          row_d   = '0;
        end else begin
          row_d = row_q + CntW'(1);
        end
      end
      StBack: begin
        // lift the queen of the previous column, resume one row below it
        occ_row = mem_rdata;
        occ_tgl = 1'b1;
        row_d   = CntW'(mem_rdata) + CntW'(1);
        state_d = StScan;
      end
      StFetch: begin
        state_d = StSend;
      end
      StSend: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          found_d     = 1'b1;
          colidx_d    = IndexW'(col_q);
          rowidx_d    = IndexW'(mem_rdata);
          last_d      = is_last;
          col_d       = col_q + CntW'(1);
          state_d     = is_last ? StIdle : StFetch;
        end
      end
      StFail: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          found_d     = 1'b0;
          colidx_d    = '0;
          rowidx_d    = '0;
          last_d      = 1'b1;
          col_d       = '0;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      n_q         <= '0;
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      colidx_q    <= '0;
      rowidx_q    <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      col_q       <= col_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
      found_q     <= found_d;
      colidx_q    <= colidx_d;
      rowidx_q    <= rowidx_d;
      last_q      <= last_d;
    end
  end

  assign in_ready_o     = (state_q == StIdle);
  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign column_index_o = colidx_q;
  assign row_index_o    = rowidx_q;
  assign last_o         = last_q;

  a_fail_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> last_o)
    else $error("failure result without last");

  a_scan_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StScan |-> row_q <= n_q && col_q <= n_q)
    else $error("search pointers beyond board size");

  a_back_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StBack |-> col_q < n_q && $past(state_q) == StScan)
    else $error("backtrack from an invalid column");

  a_fail_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StFail |-> !(found_d && out_valid_d && !out_valid_q))
    else $error("failure path reported a placement");

endmodule

// File: tb/tb.sv
module tb;
  import nqs_pkg::*;

  localparam int unsigned MaxSize = DefaultMaxSize;
  localparam int unsigned HoldCycles = 3000;
  localparam int unsigned RandomBoards = 76;
  localparam int unsigned StallBoards = 6;

  typedef struct packed {
    logic              found;
    logic [IndexW-1:0] column;
    logic [IndexW-1:0] row;
    logic              last;
  } placement_t;

  typedef struct packed {
    logic [BoardSizeW-1:0] size;
    logic                  literal;
    placement_t            result;
  } board_case_t;

  localparam placement_t NoPlacement = '{found: 1'b0, column: '0, row: '0, last: 1'b1};
  localparam placement_t LoneQueen   = '{found: 1'b1, column: '0, row: '0, last: 1'b1};

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [BoardSizeW-1:0] board_size_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic                  found_o;
  logic [IndexW-1:0]     column_index_o;
  logic [IndexW-1:0]     row_index_o;
  logic                  last_o;

  bit quiet_stretch = 1'b0;
  bit stall_request = 1'b0;
  int unsigned mismatches = 0;

  placement_t expected_placements[$];
  logic [IndexW-1:0] queen_row [MaxSize];
  placement_t got_placement;
  placement_t want_placement;

  board_case_t directed_boards [18] = '{
    '{5'd0,  1'b1, NoPlacement},
    '{5'd1,  1'b1, LoneQueen},
    '{5'd2,  1'b1, NoPlacement},
    '{5'd3,  1'b1, NoPlacement},
    '{5'd4,  1'b0, NoPlacement},
    '{5'd5,  1'b0, NoPlacement},
    '{5'd6,  1'b0, NoPlacement},
    '{5'd7,  1'b0, NoPlacement},
    '{5'd8,  1'b0, NoPlacement},
    '{5'd9,  1'b0, NoPlacement},
    '{5'd10, 1'b0, NoPlacement},
    '{5'd11, 1'b0, NoPlacement},
    '{5'd12, 1'b0, NoPlacement},
    '{5'd13, 1'b0, NoPlacement},
    '{5'd14, 1'b0, NoPlacement},
    '{5'd15, 1'b0, NoPlacement},
    '{5'd16, 1'b0, NoPlacement},
    '{5'd31, 1'b0, NoPlacement}
  };

  n_queens_first_solution_search #(
    .MAX_SIZE(MaxSize)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .board_size_i  (board_size_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .found_o       (found_o),
    .column_index_o(column_index_o),
    .row_index_o   (row_index_o),
    .last_o        (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #1_000_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // depth-first search, rows tried from 0 upward in each column
  function automatic void predict_placement(input logic [BoardSizeW-1:0] size);
    int unsigned n;
    int unsigned col;
    int unsigned row;
    int unsigned start;
    logic [MaxSize-1:0] rows_used;
    logic [2*MaxSize-2:0] rise_used;
    logic [2*MaxSize-2:0] fall_used;
    bit solved;
    bit done;
    placement_t p;
    n = (size > MaxSize) ? MaxSize : int'(size);
    rows_used = '0;
    rise_used = '0;
    fall_used = '0;
    col = 0;
    start = 0;
    solved = 1'b0;
    done = (n == 0);
    while (!done) begin
      if (col >= n) begin
        solved = 1'b1;
        done = 1'b1;
      end else begin
        row = start;
        while (row < n && (rows_used[row] || rise_used[row + col] ||
                           fall_used[row + MaxSize - 1 - col]))
          row++;
        if (row < n) begin
          rows_used[row] = 1'b1;
          rise_used[row + col] = 1'b1;
          fall_used[row + MaxSize - 1 - col] = 1'b1;
          queen_row[col] = row[IndexW-1:0];
          col++;
          start = 0;
        end else if (col == 0) begin
          done = 1'b1;
        end else begin
          col--;
          row = 32'(queen_row[col]);
          rows_used[row] = 1'b0;
          rise_used[row + col] = 1'b0;
          fall_used[row + MaxSize - 1 - col] = 1'b0;
          start = row + 1;
        end
      end
    end
    if (!solved) begin
      expected_placements.push_back(NoPlacement);
    end else begin
      for (int unsigned c = 0; c < n; c++) begin
        p.found = 1'b1;
        p.column = c[IndexW-1:0];
        p.row = queen_row[c];
        p.last = (c + 1 == n);
        expected_placements.push_back(p);
      end
    end
  endfunction

  function automatic logic [BoardSizeW-1:0] random_board_size();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 1) return BoardSizeW'($urandom_range(31, 16));
    if (pick < 7) return BoardSizeW'($urandom_range(15, 13));
    return BoardSizeW'($urandom_range(12, 0));
  endfunction

  task automatic offer_board(input logic [BoardSizeW-1:0] size, input logic literal,
                             input placement_t literal_result);
    int unsigned gap;
    gap = 0;
    if (!quiet_stretch) begin
      while ($urandom_range(99) < 19) gap++;
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    board_size_i <= size;
    do @(posedge clk_i); while (!in_ready_o);
    if (literal) expected_placements.push_back(literal_result);
    else predict_placement(size);
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_placements.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    for (int i = 0; i < 18; i++)
      offer_board(directed_boards[i].size, directed_boards[i].literal,
                  directed_boards[i].result);
    wait_for_results();

    // receiver holds off while boards keep coming
    stall_request = 1'b1;
    for (int i = 0; i < StallBoards; i++)
      offer_board(BoardSizeW'($urandom_range(9, 4)), 1'b0, NoPlacement);
    wait_for_results();

    for (int i = 0; i < RandomBoards; i++) begin
      quiet_stretch = (i >= 30 && i < 55);
      offer_board(random_board_size(), 1'b0, NoPlacement);
    end
    quiet_stretch = 1'b0;
    wait_for_results();
    repeat (50) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_request) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        stall_request = 1'b0;
      end
      out_ready_i <= quiet_stretch || ($urandom_range(99) >= 19);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_placement = '{found_o, column_index_o, row_index_o, last_o};
      if (expected_placements.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transaction: found=%0d col=%0d row=%0d last=%0d",
                   found_o, column_index_o, row_index_o, last_o);
      end else begin
        want_placement = expected_placements.pop_front();
        if (got_placement.found !== want_placement.found ||
            got_placement.column !== want_placement.column ||
            got_placement.row !== want_placement.row ||
            got_placement.last !== want_placement.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp found=%0d col=%0d row=%0d last=%0d, got %0d %0d %0d %0d",
                     want_placement.found, want_placement.column, want_placement.row,
                     want_placement.last, got_placement.found, got_placement.column,
                     got_placement.row, got_placement.last);
        end
      end
    end
  end

endmodule
